[hdl/scef_pkg.sv]
`timescale 1ns / 1ps

package scef_pkg;

	localparam int NODE_W  = 8;
	localparam int CNT_W   = 9;
	localparam int ENTRY_W = 9;
	localparam int END_BIT = 8;

	typedef logic [NODE_W-1:0]  node_t;
	typedef logic [CNT_W-1:0]   count_t;
	typedef logic [ENTRY_W-1:0] entry_t;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_QUERY = 1'b1
	} command_t;

	typedef enum logic [1:0] {
		VERDICT_NONE,
		VERDICT_CYCLE,
		VERDICT_RANGE
	} verdict_t;

	// source of the table read address
	typedef enum logic [2:0] {
		ASEL_FAST,
		ASEL_RDATA,
		ASEL_SLOW,
		ASEL_FFAST,
		ASEL_ENT,
		ASEL_AVAL
	} addr_sel_t;

	typedef struct packed {
		logic      command;
		node_t     node_index;
		node_t     successor;
		logic      successor_ends;
		logic      start_at_end;
	} req_beat_t;

	typedef struct packed {
		logic      cycle_found;
		node_t     entrance_node;
		logic      out_of_range;
	} rsp_beat_t;

	typedef struct packed {
		logic      wr_en;
		logic      start;
		addr_sel_t addr_sel;
		logic      ld_ffast;
		logic      ld_round;
		logic      ld_aval;
		logic      ld_ent;
		logic      set_res;
		verdict_t  verdict;
		logic      res_from_aval;
		logic      push;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_query;
		logic start_trivial;
		logic start_oor;
		logic rd_end;
		logic rd_oor;
		logic meet;
		logic ent_eq_rd;
		logic ffast_oor;
		logic aval_eq_rd;
		logic out_free;
	} ctl_sts_t;

endpackage

[hdl/scef_chan_if.sv]
`timescale 1ns / 1ps

interface scef_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[hdl/scef_ram.sv]
`timescale 1ns / 1ps

module scef_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hdl/scef_dp.sv]
`timescale 1ns / 1ps

module scef_dp #(
	parameter int MAX_NODES = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  scef_pkg::count_t     cfg_data,
	input  scef_pkg::req_beat_t  req_payload,
	input  logic                 rsp_ready,
	output logic                 rsp_valid,
	output scef_pkg::rsp_beat_t  rsp_payload,
	input  scef_pkg::ctl_cmd_t   cmd,
	output scef_pkg::ctl_sts_t   sts
);

	localparam int AW  = $clog2(MAX_NODES);
	localparam int CAP = (MAX_NODES > 511) ? 511 : MAX_NODES;

	scef_pkg::count_t    cnt_q;
	scef_pkg::count_t    cnt_eff;
	scef_pkg::node_t     slow_q;
	scef_pkg::node_t     fast_q;
	scef_pkg::node_t     ffast_q;
	scef_pkg::node_t     ent_q;
	scef_pkg::node_t     aval_q;
	scef_pkg::rsp_beat_t res_q;
	scef_pkg::rsp_beat_t out_q;
	logic                out_valid_q;
	scef_pkg::entry_t    rdata;
	scef_pkg::node_t     rnode;
	scef_pkg::node_t     raddr_node;
	logic                wr_in_range;

	assign cnt_eff = (cnt_q > scef_pkg::count_t'(CAP)) ? scef_pkg::count_t'(CAP) : cnt_q;
	assign rnode   = rdata[scef_pkg::NODE_W-1:0];

	assign wr_in_range = {9'd0, req_payload.node_index} < 17'(MAX_NODES);

	always_comb begin
		case (cmd.addr_sel)
			scef_pkg::ASEL_FAST:  raddr_node = fast_q;
			scef_pkg::ASEL_RDATA: raddr_node = rnode;
			scef_pkg::ASEL_SLOW:  raddr_node = slow_q;
			scef_pkg::ASEL_FFAST: raddr_node = ffast_q;
			scef_pkg::ASEL_ENT:   raddr_node = ent_q;
			scef_pkg::ASEL_AVAL:  raddr_node = aval_q;
			default:              raddr_node = fast_q;
		endcase
	end

	scef_ram #(
		.WIDTH (scef_pkg::ENTRY_W),
		.DEPTH (MAX_NODES)
	) u_table (
		.clk   (clk),
		.we    (cmd.wr_en && wr_in_range),
		.waddr (AW'(req_payload.node_index)),
		.wdata (req_payload.successor_ends ? scef_pkg::entry_t'(1 << scef_pkg::END_BIT)
		                                   : {1'b0, req_payload.successor}),
		.raddr (AW'(raddr_node)),
		.rdata (rdata)
	);

	always_comb begin
		sts.is_query      = (req_payload.command == scef_pkg::CMD_QUERY);
		sts.start_trivial = (cnt_eff == '0) || req_payload.start_at_end;
		sts.start_oor     = {1'b0, req_payload.node_index} >= cnt_eff;
		sts.rd_end        = rdata[scef_pkg::END_BIT];
		sts.rd_oor        = {1'b0, rnode} >= cnt_eff;
		sts.meet          = (rnode == ffast_q);
		sts.ent_eq_rd     = (ent_q == rnode);
		sts.ffast_oor     = {1'b0, ffast_q} >= cnt_eff;
		sts.aval_eq_rd    = (aval_q == rnode);
		sts.out_free      = !out_valid_q || rsp_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cfg_valid) begin
			cnt_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			slow_q <= req_payload.node_index;
			fast_q <= req_payload.node_index;
			ent_q  <= req_payload.node_index;
		end
		if (cmd.ld_ffast) begin
			ffast_q <= rnode;
		end
		if (cmd.ld_round) begin
			slow_q <= rnode;
			fast_q <= ffast_q;
		end
		if (cmd.ld_aval) begin
			aval_q <= rnode;
		end
		if (cmd.ld_ent) begin
			ent_q  <= aval_q;
			slow_q <= rnode;
		end
		if (cmd.set_res) begin
			res_q.cycle_found   <= (cmd.verdict == scef_pkg::VERDICT_CYCLE);
			res_q.out_of_range  <= (cmd.verdict == scef_pkg::VERDICT_RANGE);
			res_q.entrance_node <= (cmd.verdict != scef_pkg::VERDICT_CYCLE) ? '0 :
			                       cmd.res_from_aval ? aval_q : ent_q;
		end
		if (cmd.push) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid   = out_valid_q;
	assign rsp_payload = out_q;

endmodule

[hdl/scef_ctrl.sv]
`timescale 1ns / 1ps

module scef_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  scef_pkg::ctl_sts_t sts,
	output scef_pkg::ctl_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FA,
		ST_FB,
		ST_FC,
		ST_FD,
		ST_EB,
		ST_EC,
		ST_FIN
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (!sts.is_query) begin
						cmd.wr_en = 1'b1;
					end else begin
						cmd.start = 1'b1;
						if (sts.start_trivial) begin
							cmd.set_res = 1'b1;
							cmd.verdict = scef_pkg::VERDICT_NONE;
							state_d     = ST_FIN;
						end else if (sts.start_oor) begin
							cmd.set_res = 1'b1;
							cmd.verdict = scef_pkg::VERDICT_RANGE;
							state_d     = ST_FIN;
						end else begin
							state_d = ST_FA;
						end
					end
				end
			end
			ST_FA: begin
				cmd.addr_sel = scef_pkg::ASEL_FAST;
				state_d      = ST_FB;
			end
			// first hop of the fast walker
			ST_FB: begin
				if (sts.rd_end) begin
					cmd.set_res = 1'b1;
					cmd.verdict = scef_pkg::VERDICT_NONE;
					state_d     = ST_FIN;
				end else if (sts.rd_oor) begin
					cmd.set_res = 1'b1;
					cmd.verdict = scef_pkg::VERDICT_RANGE;
					state_d     = ST_FIN;
				end else begin
					cmd.addr_sel = scef_pkg::ASEL_RDATA;
					state_d      = ST_FC;
				end
			end
			// second hop of the fast walker
			ST_FC: begin
				cmd.ld_ffast = 1'b1;
				if (sts.rd_end) begin
					cmd.set_res = 1'b1;
					cmd.verdict = scef_pkg::VERDICT_NONE;
					state_d     = ST_FIN;
				end else begin
					cmd.addr_sel = scef_pkg::ASEL_SLOW;
					state_d      = ST_FD;
				end
			end
			// slow walker hop, then meet test
			ST_FD: begin
				if (sts.rd_end || sts.rd_oor) begin
					cmd.set_res = 1'b1;
					cmd.verdict = scef_pkg::VERDICT_RANGE;
					state_d     = ST_FIN;
				end else begin
					cmd.ld_round = 1'b1;
					if (sts.meet) begin
						if (sts.ent_eq_rd) begin
							cmd.set_res = 1'b1;
							cmd.verdict = scef_pkg::VERDICT_CYCLE;
							state_d     = ST_FIN;
						end else begin
							cmd.addr_sel = scef_pkg::ASEL_ENT;
							state_d      = ST_EB;
						end
					end else if (sts.ffast_oor) begin
						cmd.set_res = 1'b1;
						cmd.verdict = scef_pkg::VERDICT_RANGE;
						state_d     = ST_FIN;
					end else begin
						cmd.addr_sel = scef_pkg::ASEL_FFAST;
						state_d      = ST_FB;
					end
				end
			end
			ST_EB: begin
				cmd.ld_aval = 1'b1;
				if (sts.rd_end || sts.rd_oor) begin
					cmd.set_res = 1'b1;
					cmd.verdict = scef_pkg::VERDICT_RANGE;
					state_d     = ST_FIN;
				end else begin
					cmd.addr_sel = scef_pkg::ASEL_SLOW;
					state_d      = ST_EC;
				end
			end
			ST_EC: begin
				if (sts.rd_end || sts.rd_oor) begin
					cmd.set_res = 1'b1;
					cmd.verdict = scef_pkg::VERDICT_RANGE;
					state_d     = ST_FIN;
				end else begin
					cmd.ld_ent = 1'b1;
					if (sts.aval_eq_rd) begin
						cmd.set_res       = 1'b1;
						cmd.verdict       = scef_pkg::VERDICT_CYCLE;
						cmd.res_from_aval = 1'b1;
						state_d           = ST_FIN;
					end else begin
						cmd.addr_sel = scef_pkg::ASEL_AVAL;
						state_d      = ST_EB;
					end
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hdl/successor_cycle_entrance_finder.sv]
`timescale 1ns / 1ps

// Channel  Dir  Beat                                            Accepted when
// req      in   command, node_index, successor, successor_ends,
//               start_at_end                                    valid && ready
// rsp      out  cycle_found, entrance_node, out_of_range        valid && ready
// cfg      in   entry_count (9 bits)                            valid && ready
//
// A query walks the table through one registered read port: a launch, then per
// tortoise/hare round two reads for the fast walker and one for the slow walker,
// per entrance step one read each for the entrance and slow walkers, and then
// the result is posted. No request beat is taken while a query runs; a
// finished result holds in its final state until the output register is free.
// Reset clears the controller, the output valid and entry_count, not the table.
module successor_cycle_entrance_finder #(
	parameter int MAX_NODES = 256
) (
	input logic          clk,
	input logic          arst_n,
	scef_chan_if.sink    req,
	scef_chan_if.source  rsp,
	scef_chan_if.sink    cfg
);

	scef_pkg::ctl_cmd_t cmd;
	scef_pkg::ctl_sts_t sts;

	// the count register always takes a write
	assign cfg.ready = 1'b1;

	// sequencer: one query at a time, drives the datapath by command
	scef_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// table memory, walker pointers, result and output registers
	scef_dp #(
		.MAX_NODES (MAX_NODES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg.valid),
		.cfg_data    (cfg.payload),
		.req_payload (req.payload),
		.rsp_ready   (rsp.ready),
		.rsp_valid   (rsp.valid),
		.rsp_payload (rsp.payload),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule
